// ===== hdl/kecg_pkg.sv =====
// Shared types and constants for the key event click gate.
// Depends on nothing; imported by key_event_click_gate.
package kecg_pkg;

    localparam int KEY_BITS  = 8;
    localparam int KEY_SPACE = 256;
    localparam int STAMP_BITS = 32;
    localparam int GAP_BITS  = 16;
    localparam int CFG_BITS  = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int MASK_WORDS = 4;

    localparam logic [GAP_BITS-1:0] PRESS_GAP_RESET   = 16'd25;
    localparam logic [GAP_BITS-1:0] RELEASE_GAP_RESET = 16'd20;

    typedef enum logic [2:0] {
        REASON_PLAYED   = 3'd0,
        REASON_FILTERED = 3'd1,
        REASON_INJECTED = 3'd2,
        REASON_REPEAT   = 3'd3,
        REASON_TOO_SOON = 3'd4
    } reason_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FILTER_ENABLE = 3'd0,
        REG_FILTER_MASK_0 = 3'd1,
        REG_FILTER_MASK_1 = 3'd2,
        REG_FILTER_MASK_2 = 3'd3,
        REG_FILTER_MASK_3 = 3'd4,
        REG_PRESS_GAP     = 3'd5,
        REG_RELEASE_GAP   = 3'd6
    } cfg_reg_t;

    localparam int ACTION_RELEASE = 1;

endpackage

// ===== hdl/key_event_click_gate.sv =====
// Key event click gate: per-key press/release decision with a per-key state memory.
// Depends on kecg_pkg.
//
// Takes one key event per clock unless the output stalls and returns one decision per
// event. The per-key record (held flag, press-time-valid flag and press time) lives in a
// synchronous memory with a registered read: the event's key is read in the cycle of its
// transfer and the updated record is written back as the decision moves on, with the last
// write forwarded so that events on the same key may follow each other in consecutive
// cycles. Valid flip-flops per entry, cleared by reset, make unwritten records read as
// not held and with no recorded press, so no clearing pass is needed. An output register
// decouples the result side; one more event is taken while a result waits.
module key_event_click_gate #(
    parameter int KEY_CODES = 256,
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [kecg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [kecg_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [kecg_pkg::KEY_BITS-1:0]       key_code,
    input  logic                                injected,
    input  logic [kecg_pkg::STAMP_BITS-1:0]     time_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                play_sound,
    output logic                                press_class,
    output logic [kecg_pkg::KEY_BITS-1:0]       key_echo,
    output logic [2:0]                          reason
);
    import kecg_pkg::*;

    // Key codes are eight bits wide, so at most KEY_SPACE records are ever addressed.
    localparam int SLOTS     = (KEY_CODES < KEY_SPACE) ? KEY_CODES : KEY_SPACE;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_BITS = TIME_BITS + 2;
    localparam int CUT_BITS  = (TIME_BITS < STAMP_BITS) ? TIME_BITS : STAMP_BITS;
    localparam int CMP_BITS  = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;

    // Record layout: {held, press_valid, press_time}.
    localparam int HELD_POS  = TIME_BITS + 1;
    localparam int PVLD_POS  = TIME_BITS;

    // Configuration registers
    logic                             filter_enable_reg;
    logic [KEY_SPACE-1:0]             filter_mask_reg;
    logic [GAP_BITS-1:0]              press_gap_reg;
    logic [GAP_BITS-1:0]              release_gap_reg;

    // Key code to record slot, worked out at elaboration.
    logic [SLOT_BITS-1:0]             slot_lut [KEY_SPACE];

    // Record memory and its registered read port
    logic [WORD_BITS-1:0]             rec_mem [SLOTS];
    logic [WORD_BITS-1:0]             rd_data_reg;
    logic [SLOTS-1:0]                 rec_vld_reg;

    // Decision stage
    logic                             s1_valid_reg;
    logic                             s1_release_reg;
    logic [KEY_BITS-1:0]              s1_code_reg;
    logic                             s1_injected_reg;
    logic [STAMP_BITS-1:0]            s1_time_reg;
    logic [SLOT_BITS-1:0]             s1_slot;

    // Forwarding of the most recent write-back
    logic                             fwd_valid_reg;
    logic [SLOT_BITS-1:0]             fwd_slot_reg;
    logic [WORD_BITS-1:0]             fwd_data_reg;

    // Output register
    logic                             out_valid_reg;
    logic                             out_play_reg;
    logic                             out_class_reg;
    logic [KEY_BITS-1:0]              out_code_reg;
    reason_t                          out_reason_reg;

    logic                             in_take;
    logic                             s1_move;
    logic [SLOT_BITS-1:0]             in_slot;
    logic [WORD_BITS-1:0]             cur_rec;
    logic [TIME_BITS-1:0]             now;
    logic [TIME_BITS-1:0]             elapsed;
    logic [GAP_BITS-1:0]              gap;
    logic                             filtered;
    logic                             soon;
    logic                             wr_en;
    logic [WORD_BITS-1:0]             wr_data;
    logic                             play_next;
    reason_t                          reason_next;

    for (genvar g = 0; g < KEY_SPACE; g++)
    begin : g_slot_lut
        assign slot_lut[g] = SLOT_BITS'(g % KEY_CODES);
    end

    if (TIME_BITS > STAMP_BITS)
    begin : g_wide_time
        assign now = TIME_BITS'(s1_time_reg);
    end
    else
    begin : g_narrow_time
        assign now = s1_time_reg[CUT_BITS-1:0];
    end

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;
    assign in_slot  = slot_lut[key_code];
    assign s1_slot  = slot_lut[s1_code_reg];

    always_comb
    begin
        // A record never written since reset reads as not held and with no press time.
        if (!rec_vld_reg[s1_slot])
        begin
            cur_rec = '0;
        end
        else if (fwd_valid_reg && (fwd_slot_reg == s1_slot))
        begin
            cur_rec = fwd_data_reg;
        end
        else
        begin
            cur_rec = rd_data_reg;
        end
    end

    always_comb
    begin
        filtered    = filter_enable_reg && filter_mask_reg[s1_code_reg];
        gap         = s1_release_reg ? release_gap_reg : press_gap_reg;
        elapsed     = now - cur_rec[TIME_BITS-1:0];
        soon        = cur_rec[PVLD_POS] && (CMP_BITS'(elapsed) < CMP_BITS'(gap));
        wr_en       = 1'b0;
        wr_data     = cur_rec;
        play_next   = 1'b0;
        reason_next = REASON_PLAYED;
        priority if (filtered)
        begin
            reason_next = REASON_FILTERED;
        end
        else if (s1_injected_reg)
        begin
            reason_next = REASON_INJECTED;
        end
        else if (!s1_release_reg && cur_rec[HELD_POS])
        begin
            reason_next = REASON_REPEAT;
        end
        else
        begin
            wr_en       = 1'b1;
            play_next   = !soon;
            reason_next = soon ? REASON_TOO_SOON : REASON_PLAYED;
            if (s1_release_reg)
            begin
                wr_data[HELD_POS] = 1'b0;
            end
            else
            begin
                wr_data = {1'b1, 1'b1, now};
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            filter_mask_reg   <= '0;
            press_gap_reg     <= PRESS_GAP_RESET;
            release_gap_reg   <= RELEASE_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                REG_FILTER_MASK_0: filter_mask_reg[0*CFG_BITS +: CFG_BITS] <= cfg_data;
                REG_FILTER_MASK_1: filter_mask_reg[1*CFG_BITS +: CFG_BITS] <= cfg_data;
                REG_FILTER_MASK_2: filter_mask_reg[2*CFG_BITS +: CFG_BITS] <= cfg_data;
                REG_FILTER_MASK_3: filter_mask_reg[3*CFG_BITS +: CFG_BITS] <= cfg_data;
                REG_PRESS_GAP:     press_gap_reg   <= cfg_data[GAP_BITS-1:0];
                REG_RELEASE_GAP:   release_gap_reg <= cfg_data[GAP_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Record memory: read on transfer, written back when the decision leaves.
    always_ff @(posedge clk)
    begin
        if (s1_move && wr_en)
        begin
            rec_mem[s1_slot] <= wr_data;
        end
        if (in_take)
        begin
            rd_data_reg <= rec_mem[in_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_vld_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_move && wr_en)
        begin
            rec_vld_reg[s1_slot] <= 1'b1;
            fwd_valid_reg        <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && wr_en)
        begin
            fwd_slot_reg <= s1_slot;
            fwd_data_reg <= wr_data;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_release_reg  <= action;
            s1_code_reg     <= key_code;
            s1_injected_reg <= injected;
            s1_time_reg     <= time_ms;
        end
        if (s1_move)
        begin
            out_play_reg   <= play_next;
            out_class_reg  <= !s1_release_reg;
            out_code_reg   <= s1_code_reg;
            out_reason_reg <= reason_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign play_sound  = out_play_reg;
    assign press_class = out_class_reg;
    assign key_echo    = out_code_reg;
    assign reason      = out_reason_reg;

endmodule

// ===== verif/key_event_click_gate_tb.sv =====
// Self-checking testbench for key_event_click_gate: directed and random key events,
// with decisions predicted in the bench and compared per transfer.
// Depends on kecg_pkg and key_event_click_gate.
`timescale 1ns / 100ps

module key_event_click_gate_tb;
    import kecg_pkg::*;

    localparam logic ACT_PRESS   = 1'b0;
    localparam logic ACT_RELEASE = 1'(ACTION_RELEASE);
    localparam int   PEND_DEPTH  = 16;

    typedef struct {
        logic                  act;
        logic [KEY_BITS-1:0]   code;
        logic                  inj;
        logic [STAMP_BITS-1:0] stamp;
    } key_event_t;

    typedef struct {
        logic                play;
        logic                press_cls;
        logic [KEY_BITS-1:0] key;
        reason_t             why;
    } click_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    action = ACT_PRESS;
    logic [KEY_BITS-1:0]     key_code = '0;
    logic                    injected = 1'b0;
    logic [STAMP_BITS-1:0]   time_ms = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    play_sound;
    logic                    press_class;
    logic [KEY_BITS-1:0]     key_echo;
    logic [2:0]              reason;

    // Bench copy of the configuration and of the per-key records.
    logic                    filt_en = 1'b0;
    logic [KEY_SPACE-1:0]    filt_mask = '0;
    logic [GAP_BITS-1:0]     press_gap = PRESS_GAP_RESET;
    logic [GAP_BITS-1:0]     release_gap = RELEASE_GAP_RESET;
    logic                    held [KEY_SPACE];
    logic [STAMP_BITS-1:0]   press_stamp [KEY_SPACE];
    logic                    stamp_known [KEY_SPACE];

    // Predicted decisions in transfer order, kept in a ring with free-running counters.
    click_t                  pending_clicks [PEND_DEPTH];
    int                      pend_wr = 0;
    int                      pend_rd = 0;
    logic [STAMP_BITS-1:0]   clock_ms;
    int                      mismatches = 0;
    int                      events_sent = 0;
    int                      decisions_checked = 0;
    int                      settings_applied = 0;
    int                      reason_tally [5];
    int                      tx_calm = 0;
    int                      rx_hold = 0;
    int                      rx_calm = 0;

    key_event_click_gate DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .key_code   (key_code),
        .injected   (injected),
        .time_ms    (time_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .play_sound (play_sound),
        .press_class(press_class),
        .key_echo   (key_echo),
        .reason     (reason)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Works out the decision for one event and updates the bench's key records.
    function automatic click_t predict_click(input key_event_t ev);
        click_t                res;
        logic [STAMP_BITS-1:0] elapsed;
        logic                  too_soon;
        res.press_cls = (ev.act == ACT_PRESS);
        res.key       = ev.code;
        res.play      = 1'b0;
        if (filt_en && filt_mask[ev.code])
        begin
            res.why = REASON_FILTERED;
        end
        else if (ev.inj)
        begin
            res.why = REASON_INJECTED;
        end
        else if (ev.act == ACT_PRESS && held[ev.code])
        begin
            res.why = REASON_REPEAT;
        end
        else
        begin
            elapsed = ev.stamp - press_stamp[ev.code];
            if (ev.act == ACT_PRESS)
            begin
                too_soon = stamp_known[ev.code] && (elapsed < press_gap);
                held[ev.code]        = 1'b1;
                press_stamp[ev.code] = ev.stamp;
                stamp_known[ev.code] = 1'b1;
            end
            else
            begin
                too_soon = stamp_known[ev.code] && (elapsed < release_gap);
                held[ev.code] = 1'b0;
            end
            res.why  = too_soon ? REASON_TOO_SOON : REASON_PLAYED;
            res.play = !too_soon;
        end
        return res;
    endfunction

    function automatic key_event_t mk_event(input logic act, input int code,
                                            input logic inj, input logic [31:0] stamp);
        key_event_t ev;
        ev.act   = act;
        ev.code  = code[KEY_BITS-1:0];
        ev.inj   = inj;
        ev.stamp = stamp;
        return ev;
    endfunction

    // Mostly short gaps, now and then a long one, and calm stretches with none.
    function automatic int next_tx_gap();
        int r;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(6, 30);
        tx_calm = $urandom_range(30, 120);
        return 0;
    endfunction

    // Denser masks for low density values; higher values thin the set bits out.
    function automatic logic [KEY_SPACE-1:0] rand_mask(input int density);
        logic [KEY_SPACE-1:0] m;
        m = '1;
        repeat (density)
            for (int w = 0; w < KEY_SPACE / 32; w++)
                m[w*32 +: 32] = m[w*32 +: 32] & $urandom;
        return m;
    endfunction

    // Receiver side: random back-pressure with the same short, long and calm pattern.
    always @(posedge clk)
    begin
        int r;
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_calm > 0)
            begin
                rx_calm--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r >= 60 && r < 90)
                    rx_hold = $urandom_range(1, 3);
                else if (r >= 90 && r < 97)
                    rx_hold = $urandom_range(8, 40);
                else if (r >= 97)
                    rx_calm = $urandom_range(50, 200);
            end
        end
    end

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        click_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pend_wr == pend_rd)
            begin
                report_mismatch($sformatf("decision for key %0d with nothing expected",
                                          key_echo));
            end
            else
            begin
                want = pending_clicks[pend_rd % PEND_DEPTH];
                pend_rd++;
                decisions_checked++;
                reason_tally[want.why]++;
                if (play_sound !== want.play)
                    report_mismatch($sformatf("key %0d: play_sound %b, expected %b",
                                              want.key, play_sound, want.play));
                if (press_class !== want.press_cls)
                    report_mismatch($sformatf("key %0d: press_class %b, expected %b",
                                              want.key, press_class, want.press_cls));
                if (key_echo !== want.key)
                    report_mismatch($sformatf("key_echo %0d, expected %0d",
                                              key_echo, want.key));
                if (reason !== want.why)
                    report_mismatch($sformatf("key %0d: reason %0d, expected %s",
                                              want.key, reason, want.why.name()));
            end
        end
    end

    // Drives one event and waits for its transfer; valid stays high into the next event
    // when no gap follows.
    task automatic send_event(input key_event_t ev);
        int idle;
        idle = next_tx_gap();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            action   <= 1'($urandom_range(0, 1));
            key_code <= KEY_BITS'($urandom_range(0, 255));
            injected <= 1'($urandom_range(0, 1));
            time_ms  <= $urandom;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= ev.act;
        key_code <= ev.code;
        injected <= ev.inj;
        time_ms  <= ev.stamp;
        do @(posedge clk); while (!in_ready);
        pending_clicks[pend_wr % PEND_DEPTH] = predict_click(ev);
        pend_wr++;
        events_sent++;
    endtask

    // Stops input and waits, with a limit, until every predicted decision has arrived.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pend_wr != pend_rd && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pend_wr != pend_rd)
        begin
            report_mismatch($sformatf("%0d decisions never arrived", pend_wr - pend_rd));
            pend_rd = pend_wr;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        unique case (idx)
            REG_FILTER_ENABLE: filt_en = value[0];
            REG_FILTER_MASK_0: filt_mask[0*64 +: 64] = value;
            REG_FILTER_MASK_1: filt_mask[1*64 +: 64] = value;
            REG_FILTER_MASK_2: filt_mask[2*64 +: 64] = value;
            REG_FILTER_MASK_3: filt_mask[3*64 +: 64] = value;
            REG_PRESS_GAP:     press_gap = value[GAP_BITS-1:0];
            REG_RELEASE_GAP:   release_gap = value[GAP_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Narrow registers get random upper bits, which the block must ignore.
    task automatic write_all_regs(input logic en, input logic [KEY_SPACE-1:0] mask,
                                  input logic [GAP_BITS-1:0] pg,
                                  input logic [GAP_BITS-1:0] rg);
        logic [CFG_BITS-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_FILTER_ENABLE, {junk[CFG_BITS-1:1], en});
        write_reg(REG_FILTER_MASK_0, mask[0*64 +: 64]);
        write_reg(REG_FILTER_MASK_1, mask[1*64 +: 64]);
        write_reg(REG_FILTER_MASK_2, mask[2*64 +: 64]);
        write_reg(REG_FILTER_MASK_3, mask[3*64 +: 64]);
        write_reg(REG_PRESS_GAP, {junk[CFG_BITS-1:GAP_BITS], pg});
        write_reg(REG_RELEASE_GAP, {~junk[CFG_BITS-1:GAP_BITS], rg});
        settings_applied++;
    endtask

    // Reset gaps of 25 and 20 ms, first presses with no recorded time, wrap of the
    // timestamp and auto-repeat.
    task automatic test_reset_defaults();
        send_event(mk_event(ACT_PRESS,   0,   1'b0, 32'd0));
        send_event(mk_event(ACT_RELEASE, 0,   1'b0, 32'd5));
        send_event(mk_event(ACT_PRESS,   0,   1'b0, 32'd10));
        send_event(mk_event(ACT_RELEASE, 0,   1'b0, 32'd40));
        send_event(mk_event(ACT_RELEASE, 200, 1'b0, 32'd41));
        send_event(mk_event(ACT_PRESS,   255, 1'b0, 32'hFFFF_FFF0));
        send_event(mk_event(ACT_RELEASE, 255, 1'b0, 32'h0000_0010));
        send_event(mk_event(ACT_PRESS,   255, 1'b0, 32'h0000_0005));
        send_event(mk_event(ACT_PRESS,   255, 1'b0, 32'h0000_0090));
        send_event(mk_event(ACT_RELEASE, 255, 1'b0, 32'hFFFF_FFFF));
    endtask

    // Injected events leave every record alone, so an injected release keeps the key held.
    task automatic test_injected_events();
        send_event(mk_event(ACT_PRESS,   8'h5A, 1'b1, 32'd1000));
        send_event(mk_event(ACT_PRESS,   8'h5A, 1'b0, 32'd1001));
        send_event(mk_event(ACT_RELEASE, 8'h5A, 1'b1, 32'd1100));
        send_event(mk_event(ACT_PRESS,   8'h5A, 1'b0, 32'd1200));
        send_event(mk_event(ACT_RELEASE, 8'h5A, 1'b0, 32'd1203));
    endtask

    // The filter is checked before the injected flag, and only while enabled.
    task automatic test_filter_priority();
        settle();
        write_all_regs(1'b1, {64'h8000_0000_0000_0000, 64'h0, 64'h1, {64{1'b1}}},
                       PRESS_GAP_RESET, RELEASE_GAP_RESET);
        send_event(mk_event(ACT_PRESS,   0,   1'b0, 32'd2000));
        send_event(mk_event(ACT_PRESS,   255, 1'b1, 32'd2001));
        send_event(mk_event(ACT_RELEASE, 63,  1'b0, 32'd2002));
        send_event(mk_event(ACT_PRESS,   64,  1'b0, 32'd2003));
        send_event(mk_event(ACT_PRESS,   65,  1'b1, 32'd2004));
        settle();
        write_all_regs(1'b0, {64'h8000_0000_0000_0000, 64'h0, 64'h1, {64{1'b1}}},
                       PRESS_GAP_RESET, RELEASE_GAP_RESET);
        send_event(mk_event(ACT_PRESS,   0,   1'b0, 32'd2010));
    endtask

    // Zero and full-scale gaps right at their thresholds.
    task automatic test_gap_extremes();
        settle();
        write_all_regs(1'b0, '0, 16'd0, 16'hFFFF);
        send_event(mk_event(ACT_PRESS,   8'h41, 1'b0, 32'd5000));
        send_event(mk_event(ACT_RELEASE, 8'h41, 1'b0, 32'd5000 + 32'd65534));
        send_event(mk_event(ACT_PRESS,   8'h41, 1'b0, 32'd5000 + 32'd65534));
        send_event(mk_event(ACT_RELEASE, 8'h41, 1'b0, 32'd5000 + 32'd131069));
        settle();
        write_all_regs(1'b0, '0, 16'hFFFF, 16'd0);
        send_event(mk_event(ACT_PRESS,   8'h41, 1'b0, 32'd5000 + 32'd131070));
        send_event(mk_event(ACT_RELEASE, 8'h41, 1'b0, 32'd5000 + 32'd131070));
    endtask

    // Random traffic on a small pool of keys, mostly well-formed press/release pairs with
    // timestamps clustered around the gap thresholds; the rest is noise.
    task automatic test_random_traffic(input logic en, input logic [KEY_SPACE-1:0] mask,
                                       input logic [GAP_BITS-1:0] pg,
                                       input logic [GAP_BITS-1:0] rg,
                                       input int count, input logic [31:0] start_ms);
        int                    pool [8];
        int                    k;
        logic [STAMP_BITS-1:0] thr;
        key_event_t            ev;
        settle();
        write_all_regs(en, mask, pg, rg);
        clock_ms = start_ms;
        foreach (pool[i]) pool[i] = $urandom_range(0, 255);
        repeat (count)
        begin
            k = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)]
                                           : $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: clock_ms += $urandom_range(0, 40);
                4, 5, 6:
                begin
                    thr = STAMP_BITS'($urandom_range(0, 1) ? pg : rg);
                    clock_ms += thr + $urandom_range(0, 2) - 1;
                end
                7, 8: clock_ms += $urandom_range(0, 70000);
                default: clock_ms = $urandom;
            endcase
            ev.code  = k[KEY_BITS-1:0];
            ev.inj   = ($urandom_range(0, 99) < 8);
            ev.stamp = clock_ms;
            if ($urandom_range(0, 99) < 85)
                ev.act = held[k] ? ACT_RELEASE : ACT_PRESS;
            else
                ev.act = 1'($urandom_range(0, 1));
            send_event(ev);
        end
    endtask

    initial
    begin
        foreach (held[i])
        begin
            held[i]        = 1'b0;
            stamp_known[i] = 1'b0;
            press_stamp[i] = '0;
        end
        foreach (reason_tally[i]) reason_tally[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_injected_events();
        test_filter_priority();
        test_gap_extremes();

        test_random_traffic(1'b0, rand_mask(1), 16'd25, 16'd20, 120, $urandom);
        test_random_traffic(1'b1, rand_mask(1), GAP_BITS'($urandom_range(1, 50)),
                            GAP_BITS'($urandom_range(1, 50)), 130, 32'hFFFF_FF00);
        test_random_traffic(1'b1, '1, 16'd30, 16'd10, 30, $urandom);
        test_random_traffic(1'b1, '0, 16'd0, 16'd0, 100, $urandom);
        test_random_traffic(1'b0, rand_mask(1), 16'hFFFF, 16'hFFFF, 100, 32'hFFFE_0000);
        test_random_traffic(1'b1, rand_mask(3), GAP_BITS'($urandom_range(0, 200)),
                            GAP_BITS'($urandom_range(0, 200)), 170, $urandom);

        settle();
        repeat (8) @(posedge clk);
        $display("Covered %0d key events and %0d checked decisions over %0d register settings.",
                 events_sent, decisions_checked, settings_applied);
        $display("Decisions seen: %0d played, %0d filtered, %0d injected, %0d repeat, %0d early.",
                 reason_tally[REASON_PLAYED], reason_tally[REASON_FILTERED],
                 reason_tally[REASON_INJECTED], reason_tally[REASON_REPEAT],
                 reason_tally[REASON_TOO_SOON]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run stopped at the time limit with %0d decisions outstanding.",
                 pend_wr - pend_rd);
        $display("Mismatches found");
        $finish;
    end

endmodule
